[hw/rtl/scp_pkg.sv]
//------------------------------------------------------------------------------
// scp_pkg
// shared types and constants of the section cycle profiler
//------------------------------------------------------------------------------
package scp_pkg;

   localparam int SLOTS = 16;
   localparam int SLOT_W = 4;
   // slot memory word: start, count, sum, worst
   localparam int SLOT_WORD_W = 160;
   localparam logic [9:0] RESET_CYCLES_PER_US = 10'd170;
   localparam logic [31:0] RESET_WINDOW = 32'd170000000;
   localparam logic [19:0] RATE_NUMERATOR = 20'd1000000;

   typedef enum logic [1:0] {
      OP_BEGIN = 2'd0,
      OP_END   = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [0:0] {
      CSR_CYCLES_PER_US = 1'b0,
      CSR_REPORT_WINDOW = 1'b1
   } csr_index_type;

   // divider handshake
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;

endpackage

[hw/rtl/section_cycle_profiler_core.sv]
//------------------------------------------------------------------------------
// section_cycle_profiler_core
// section and loop cycle profiler with periodic report records
//------------------------------------------------------------------------------
// Begin and end transactions pass through a slot memory read and an update,
// a tick that does not report through the tick state alone. A reporting tick
// first sweeps the sixteen slots one per cycle, then produces each record
// through one shared 64-bit serial divider: the loop record needs up to five
// divisions and each slot record three, plus a fetch of each slot record
// and its hand-over, which waits while the receiver stalls. The clearing of
// slot statistics is a pass over all sixteen slots after every report and
// after reset; no transaction is taken meanwhile.
module section_cycle_profiler_core
   import scp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[1:0]
   input  logic [1:0]  req_tuser,
   // slot[3:0], timestamp[35:4], zero fill
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // slot_index[3:0], event_count[35:4], average_us[67:36], worst_us[99:68],
   // average_rate_hz[119:100], lowest_rate_hz[139:120], zero fill
   output logic [143:0] rsp_tdata,
   // record_kind[0]
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_UPDATE, ST_TICK, ST_SCAN,
      ST_DIV_MEAN, ST_DIV_US, ST_DIV_WORST, ST_DIV_AHZ, ST_DIV_LHZ,
      ST_EMIT, ST_NEXT
   } state_type;

   state_type   state_ff;
   logic [9:0]  cpu_ff;
   logic [31:0] window_ff;
   logic [1:0]  op_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [31:0] ts_ff;
   logic [31:0] prev_tick_ff, tick_count_ff, tick_worst_ff, window_start_ff;
   logic [63:0] tick_sum_ff;
   logic [SLOT_W:0] idx_ff;
   logic [SLOTS-1:0] ran_ff;
   logic [31:0] cnt_ff, avg_ff, worst_ff;
   logic [19:0] ahz_ff, lhz_ff;
   logic [63:0] sum_ff;
   logic        kind_ff, last_ff;
   logic        rsp_valid_ff;
   logic        pend_ff;

   logic                   ram_we;
   logic [SLOT_W-1:0]      ram_addr;
   logic [SLOT_WORD_W-1:0] ram_wdata, ram_rdata;
   div_req_type            dreq;
   div_rsp_type            drsp;

   logic [31:0] r_start, r_count, r_worst, d_slot, d_tick;
   logic [63:0] r_sum;
   logic [31:0] elapsed;
   logic [63:0] cpu64;
   logic [SLOTS-1:0] ran_rest;

   assign r_start = ram_rdata[31:0];
   assign r_count = ram_rdata[63:32];
   assign r_sum   = ram_rdata[127:64];
   assign r_worst = ram_rdata[159:128];
   assign d_slot  = ts_ff - r_start;
   assign d_tick  = ts_ff - prev_tick_ff;
   assign elapsed = ts_ff - window_start_ff;
   assign cpu64   = {54'd0, (cpu_ff == 10'd0) ? 10'd1 : cpu_ff};
   assign ran_rest = ran_ff >> (idx_ff + (SLOT_W+1)'(1));

   scp_ram #(.WIDTH(SLOT_WORD_W), .DEPTH(SLOTS)) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   scp_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = slot_ff;
      ram_wdata = '0;
      dreq      = '{start: 1'b0, dividend: '0, divisor: 64'd1};
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we   = 1'b1;
            ram_addr = idx_ff[SLOT_W-1:0];
         end
         ST_UPDATE: begin
            ram_we = 1'b1;
            if (op_ff == OP_BEGIN) begin
               ram_wdata = {r_worst, r_sum, r_count, ts_ff};
            end else begin
               ram_wdata = {(d_slot > r_worst) ? d_slot : r_worst,
                            r_sum + {32'd0, d_slot}, r_count + 32'd1, r_start};
            end
         end
         ST_SCAN, ST_NEXT: ram_addr = idx_ff[SLOT_W-1:0];
         ST_DIV_MEAN, ST_DIV_US, ST_DIV_WORST, ST_DIV_AHZ, ST_DIV_LHZ:
            ram_addr = idx_ff[SLOT_W-1:0];
         default: ram_addr = slot_ff;
      endcase
      if (pend_ff) begin
         unique case (state_ff)
            ST_DIV_MEAN:  dreq = '{1'b1, sum_ff, {32'd0, cnt_ff}};
            ST_DIV_US:    dreq = '{1'b1, sum_ff, cpu64};
            ST_DIV_WORST: dreq = '{1'b1, {32'd0, worst_ff}, cpu64};
            ST_DIV_AHZ:   dreq = '{1'b1, {44'd0, RATE_NUMERATOR}, {32'd0, avg_ff}};
            ST_DIV_LHZ:   dreq = '{1'b1, {44'd0, RATE_NUMERATOR}, {32'd0, worst_ff}};
            default:      dreq.start = 1'b0;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {4'd0, lhz_ff, ahz_ff, worst_ff, avg_ff, cnt_ff, slot_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         idx_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         pend_ff         <= 1'b0;
         prev_tick_ff    <= '0;
         tick_count_ff   <= '0;
         tick_sum_ff     <= '0;
         tick_worst_ff   <= '0;
         window_start_ff <= '0;
         cpu_ff          <= RESET_CYCLES_PER_US;
         window_ff       <= RESET_WINDOW;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_CYCLES_PER_US: cpu_ff <= csr_wdata[9:0];
               CSR_REPORT_WINDOW: window_ff <= csr_wdata;
            endcase
         end
         unique case (state_ff)
            ST_CLEAR: begin
               pend_ff <= 1'b0;
               idx_ff  <= idx_ff + (SLOT_W+1)'(1);
               if (idx_ff == (SLOT_W+1)'(SLOTS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               pend_ff <= 1'b0;
               if (req_tvalid) begin
                  op_ff   <= req_tuser;
                  slot_ff <= req_tdata[3:0];
                  ts_ff   <= req_tdata[35:4];
                  if (req_tuser == OP_BEGIN || req_tuser == OP_END) begin
                     state_ff <= ST_READ;
                  end else if (req_tuser == OP_TICK) begin
                     state_ff <= ST_TICK;
                  end
               end
            end
            ST_READ: begin
               // slot record load after memory read
               pend_ff <= (op_ff == OP_NONE);
               if (op_ff == OP_NONE) begin
                  cnt_ff   <= r_count;
                  sum_ff   <= r_sum;
                  worst_ff <= r_worst;
                  ahz_ff   <= '0;
                  lhz_ff   <= '0;
                  state_ff <= ST_DIV_MEAN;
               end else begin
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               pend_ff  <= 1'b0;
               state_ff <= ST_IDLE;
            end
            ST_TICK: begin
               pend_ff       <= 1'b0;
               prev_tick_ff  <= ts_ff;
               tick_count_ff <= tick_count_ff + 32'd1;
               tick_sum_ff   <= tick_sum_ff + {32'd0, d_tick};
               if (d_tick > tick_worst_ff) begin
                  tick_worst_ff <= d_tick;
               end
               if (elapsed < window_ff) begin
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_SCAN;
                  idx_ff   <= '0;
                  ran_ff   <= '0;
               end
            end
            ST_SCAN: begin
               // memory read of idx lands in the next cycle
               if (idx_ff != '0) begin
                  ran_ff[idx_ff[SLOT_W-1:0] - SLOT_W'(1)] <= (r_count != 32'd0);
               end
               idx_ff  <= idx_ff + (SLOT_W+1)'(1);
               pend_ff <= (idx_ff == (SLOT_W+1)'(SLOTS));
               if (idx_ff == (SLOT_W+1)'(SLOTS)) begin
                  kind_ff  <= 1'b0;
                  slot_ff  <= '0;
                  cnt_ff   <= tick_count_ff;
                  sum_ff   <= tick_sum_ff;
                  worst_ff <= tick_worst_ff;
                  ahz_ff   <= '0;
                  lhz_ff   <= '0;
                  state_ff <= ST_DIV_MEAN;
               end
            end
            ST_DIV_MEAN: begin
               pend_ff <= (cnt_ff == 32'd0) || drsp.done;
               if (cnt_ff == 32'd0) begin
                  sum_ff   <= '0;
                  state_ff <= ST_DIV_US;
               end else if (drsp.done) begin
                  sum_ff   <= drsp.quotient;
                  state_ff <= ST_DIV_US;
               end
            end
            ST_DIV_US: begin
               pend_ff <= drsp.done;
               if (drsp.done) begin
                  avg_ff   <= drsp.quotient[31:0];
                  state_ff <= ST_DIV_WORST;
               end
            end
            ST_DIV_WORST: begin
               pend_ff <= drsp.done;
               if (drsp.done) begin
                  worst_ff <= drsp.quotient[31:0];
                  state_ff <= kind_ff ? ST_EMIT : ST_DIV_AHZ;
                  if (kind_ff) begin
                     rsp_valid_ff <= 1'b1;
                     last_ff      <= (ran_rest == '0);
                  end
               end
            end
            ST_DIV_AHZ: begin
               pend_ff <= (avg_ff == 32'd0) || drsp.done;
               if (avg_ff == 32'd0) begin
                  state_ff <= ST_DIV_LHZ;
               end else if (drsp.done) begin
                  ahz_ff   <= drsp.quotient[19:0];
                  state_ff <= ST_DIV_LHZ;
               end
            end
            ST_DIV_LHZ: begin
               pend_ff <= 1'b0;
               if (worst_ff == 32'd0 || drsp.done) begin
                  if (worst_ff != 32'd0) begin
                     lhz_ff <= drsp.quotient[19:0];
                  end
                  rsp_valid_ff <= 1'b1;
                  last_ff      <= (ran_ff == '0);
                  idx_ff       <= '0;
                  state_ff     <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               pend_ff <= 1'b0;
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  if (last_ff) begin
                     tick_count_ff   <= '0;
                     tick_sum_ff     <= '0;
                     tick_worst_ff   <= '0;
                     window_start_ff <= ts_ff;
                     idx_ff          <= '0;
                     state_ff        <= ST_CLEAR;
                  end else begin
                     if (kind_ff) begin
                        idx_ff <= idx_ff + (SLOT_W+1)'(1);
                     end
                     state_ff <= ST_NEXT;
                  end
               end
            end
            ST_NEXT: begin
               // skip idle slots; the read for idx is issued here
               pend_ff <= 1'b0;
               if (idx_ff[SLOT_W] || !ran_ff[idx_ff[SLOT_W-1:0]]) begin
                  idx_ff <= idx_ff + (SLOT_W+1)'(1);
               end else begin
                  state_ff <= ST_READ;
                  kind_ff  <= 1'b1;
                  slot_ff  <= idx_ff[SLOT_W-1:0];
                  op_ff    <= OP_NONE;
               end
            end
            default: begin
               pend_ff  <= 1'b0;
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_no_accept_during_report: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while a record is pending");
   a_record_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
         $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("record changed before transaction");
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> tick_count_ff == 32'd0)
      else $error("loop statistics not cleared after report");
`endif

endmodule

[hw/rtl/scp_ram.sv]
//------------------------------------------------------------------------------
// scp_ram
// generic single-port ram with registered read
//------------------------------------------------------------------------------
module scp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

[hw/rtl/scp_divider.sv]
//------------------------------------------------------------------------------
// scp_divider
// 64-bit restoring divider, one quotient bit per cycle; the user must keep the divisor nonzero, it is not enforced here
//------------------------------------------------------------------------------
module scp_divider
   import scp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [63:0] quo_ff, quo_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[63]} - {1'b0, dvs_ff};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[64]) begin
            rem_in = {rem_ff[62:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end else begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

[sim/tb_section_cycle_profiler_core.sv]
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_section_cycle_profiler_core
// self-checking bench: section, loop and report behaviour against a local
// predictor, under several idle and stall patterns and csr settings
//------------------------------------------------------------------------------
module tb_section_cycle_profiler_core
   import scp_pkg::*;
();

   typedef struct packed {
      logic        kind;
      logic [3:0]  slot;
      logic [31:0] count;
      logic [31:0] avg_us;
      logic [31:0] worst_us;
      logic [19:0] avg_hz;
      logic [19:0] low_hz;
      logic        last;
   } profile_record_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [1:0]   req_tuser = '0;
   logic [39:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [143:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we = 1'b0;
   logic         csr_index = 1'b0;
   logic [31:0]  csr_wdata = '0;

   // predictor state
   logic [9:0]  m_cpu;
   logic [31:0] m_window;
   logic [31:0] m_start [SLOTS];
   logic [31:0] m_count [SLOTS];
   logic [63:0] m_sum [SLOTS];
   logic [31:0] m_worst [SLOTS];
   logic [31:0] m_prev, m_tcount, m_tworst, m_wstart, ts_now;
   logic [63:0] m_tsum;

   profile_record_type report_queue [$];
   int errors = 0;
   int send_idle = 0;
   int recv_stall = 0;
   bit hold_off = 1'b0;

   section_cycle_profiler_core DUT (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic logic [31:0] cycles_to_us(logic [63:0] cyc);
      logic [63:0] d;
      d = (m_cpu == 0) ? 64'd1 : {54'd0, m_cpu};
      return 32'(cyc / d);
   endfunction

   function automatic logic [31:0] mean_of(logic [63:0] sum, logic [31:0] cnt);
      if (cnt == 0) return 32'd0;
      return cycles_to_us(sum / {32'd0, cnt});
   endfunction

   task automatic clear_profile();
      for (int i = 0; i < SLOTS; i++) begin
         m_start[i] = 0; m_count[i] = 0; m_sum[i] = 0; m_worst[i] = 0;
      end
      m_tcount = 0; m_tsum = 0; m_tworst = 0;
   endtask

   task automatic predict_event(opcode_type op, logic [3:0] s, logic [31:0] ts);
      logic [31:0] d, a, w;
      int ran, seen;
      profile_record_type r;
      ran = 0; seen = 0;
      if (op == OP_BEGIN) begin
         m_start[s] = ts;
      end else if (op == OP_END) begin
         d = ts - m_start[s];
         m_count[s] += 1; m_sum[s] += {32'd0, d};
         if (d > m_worst[s]) m_worst[s] = d;
      end else if (op == OP_TICK) begin
         d = ts - m_prev; m_prev = ts;
         m_tcount += 1; m_tsum += {32'd0, d};
         if (d > m_tworst) m_tworst = d;
         if (ts - m_wstart >= m_window) begin
            for (int i = 0; i < SLOTS; i++) if (m_count[i] != 0) ran++;
            a = mean_of(m_tsum, m_tcount);
            w = cycles_to_us({32'd0, m_tworst});
            r = '{1'b0, 4'd0, m_tcount, a, w,
                  20'(a != 0 ? 32'(RATE_NUMERATOR) / a : 0),
                  20'(w != 0 ? 32'(RATE_NUMERATOR) / w : 0), ran == 0};
            report_queue.push_back(r);
            for (int i = 0; i < SLOTS; i++) begin
               if (m_count[i] != 0) begin
                  seen++;
                  r = '{1'b1, 4'(i), m_count[i], mean_of(m_sum[i], m_count[i]),
                        cycles_to_us({32'd0, m_worst[i]}), 20'd0, 20'd0, seen == ran};
                  report_queue.push_back(r);
               end
            end
            clear_profile();
            m_wstart = ts;
         end
      end
   endtask

   task automatic send_event(opcode_type op, logic [3:0] s, logic [31:0] ts);
      int gap;
      gap = (send_idle > 0 && $urandom_range(99) < send_idle) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'd0, ts, s};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_event(op, s, ts);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (report_queue.size() != 0) @(negedge clock);
      repeat (1500) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] val);
      wait_drained();
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_CYCLES_PER_US) m_cpu = val[9:0];
      else m_window = val;
   endtask

   // well-formed section pairs with ticks, plus noise
   task automatic random_burst(int n);
      logic [3:0] s;
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         s = 4'($urandom);
         if (k < 30) begin
            send_event(OP_BEGIN, s, ts_now);
            ts_now += $urandom_range(0, 5000);
            send_event(OP_END, s, ts_now);
            i++;
         end else if (k < 60) begin
            ts_now += ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 3000);
            send_event(OP_TICK, s, ts_now);
         end else if (k < 70) begin
            send_event(OP_NONE, s, $urandom);
         end else begin
            send_event(opcode_type'($urandom_range(0, 2)), s, $urandom);
         end
      end
   endtask

   task automatic test_directed();
      send_event(OP_TICK, 4'd0, 32'd100);
      send_event(OP_BEGIN, 4'd0, 32'hFFFF_FFF0);
      send_event(OP_END, 4'd0, 32'h0000_0010);
      send_event(OP_BEGIN, 4'd15, 32'd0);
      send_event(OP_END, 4'd15, 32'hFFFF_FFFF);
      send_event(OP_END, 4'd7, 32'd55);
      send_event(OP_NONE, 4'd15, 32'hFFFF_FFFF);
      send_event(OP_TICK, 4'd0, 32'hFFFF_FFFF);
      send_event(OP_TICK, 4'd3, 32'h8000_0000);
      write_csr(CSR_REPORT_WINDOW, 32'd0);
      send_event(OP_TICK, 4'd0, 32'd5);
      send_event(OP_TICK, 4'd0, 32'd5);
      write_csr(CSR_CYCLES_PER_US, 10'd0);
      send_event(OP_BEGIN, 4'd2, 32'd0);
      send_event(OP_END, 4'd2, 32'd1);
      send_event(OP_TICK, 4'd0, 32'd2000006);
      write_csr(CSR_CYCLES_PER_US, 10'd1023);
      send_event(OP_TICK, 4'd1, 32'hFFFF_FFFF);
      write_csr(CSR_REPORT_WINDOW, 32'hFFFF_FFFF);
      send_event(OP_TICK, 4'd1, 32'd10);
      ts_now = 32'd1000;
   endtask

   task automatic test_random();
      write_csr(CSR_CYCLES_PER_US, 10'd17);
      write_csr(CSR_REPORT_WINDOW, 32'd20000);
      send_idle = 0; recv_stall = 0;
      random_burst(100);
      send_idle = 83;
      random_burst(100);
      write_csr(CSR_CYCLES_PER_US, 10'd1);
      write_csr(CSR_REPORT_WINDOW, 32'd5000);
      send_idle = 0; recv_stall = 83;
      random_burst(100);
      send_idle = 31; recv_stall = 31;
      random_burst(90);
   endtask

   task automatic test_backpressure();
      write_csr(CSR_REPORT_WINDOW, 32'd0);
      send_idle = 0; recv_stall = 0;
      hold_off = 1'b1;
      for (int i = 0; i < 20; i++) begin
         ts_now += $urandom_range(1, 900);
         send_event(OP_TICK, 4'd0, ts_now);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      profile_record_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tuser, rsp_tdata[3:0], rsp_tdata[35:4], rsp_tdata[67:36],
                 rsp_tdata[99:68], rsp_tdata[119:100], rsp_tdata[139:120], rsp_tlast};
         if (report_queue.size() == 0) begin
            $error("unexpected record transaction");
            errors++;
         end else begin
            want = report_queue.pop_front();
            if (got.kind !== want.kind) begin
               $error("record_kind exp %0d got %0d", want.kind, got.kind); errors++;
            end
            if (got.slot !== want.slot) begin
               $error("slot_index exp %0d got %0d", want.slot, got.slot); errors++;
            end
            if (got.count !== want.count) begin
               $error("event_count exp %0d got %0d", want.count, got.count); errors++;
            end
            if (got.avg_us !== want.avg_us) begin
               $error("average_us exp %0d got %0d", want.avg_us, got.avg_us); errors++;
            end
            if (got.worst_us !== want.worst_us) begin
               $error("worst_us exp %0d got %0d", want.worst_us, got.worst_us); errors++;
            end
            if (got.avg_hz !== want.avg_hz) begin
               $error("average_rate_hz exp %0d got %0d", want.avg_hz, got.avg_hz); errors++;
            end
            if (got.low_hz !== want.low_hz) begin
               $error("lowest_rate_hz exp %0d got %0d", want.low_hz, got.low_hz); errors++;
            end
            if (got.last !== want.last) begin
               $error("last_record exp %0d got %0d", want.last, got.last); errors++;
            end
         end
      end
   end

   // receiver: random stalls and one long hold-off
   initial begin
      int held;
      held = 0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            held++;
            if (held >= 6000) hold_off = 1'b0;
         end else begin
            rsp_tready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
         end
      end
   end

   initial begin
      m_cpu = RESET_CYCLES_PER_US; m_window = RESET_WINDOW;
      m_prev = 0; m_wstart = 0; ts_now = 0;
      clear_profile();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random();
      test_backpressure();
      recv_stall = 0;
      wait_drained();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[section_cycle_profiler_core.f]
hw/rtl/scp_pkg.sv
hw/rtl/scp_ram.sv
hw/rtl/scp_divider.sv
hw/rtl/section_cycle_profiler_core.sv
sim/tb_section_cycle_profiler_core.sv
